@@ rtl/blpc_pkg.sv @@
package blpc_pkg;

    // Key slots of the multi-function keys
    localparam int NUM_KEYS   = 3;
    localparam int KEY_ORANGE = 0;
    localparam int KEY_SK1    = 1;
    localparam int KEY_SK2    = 2;

    // Result word: keys_down | short << 4 | long << 7 | xlong << 10
    localparam int KEYS_W = 4;
    localparam int WORD_W = KEYS_W + 3 * NUM_KEYS;

    localparam int ELAPSED_W  = 16;
    localparam int CFG_DATA_W = 24;

    localparam int CFG_INDEX_W = 1;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;
    typedef logic [NUM_KEYS-1:0]    t_key_mask;
    typedef logic [KEYS_W-1:0]      t_keys;
    typedef logic [ELAPSED_W-1:0]   t_elapsed;
    typedef logic [WORD_W-1:0]      t_word;

    localparam t_cfg_index CFG_LONG_PRESS_TICKS   = 1'd0;
    localparam t_cfg_index CFG_ORANGE_KEY_PRESENT = 1'd1;

    localparam t_cfg_data LONG_PRESS_RESET = 24'd5000;

endpackage

@@ rtl/button_long_press_classifier_unit.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// poll in  | i_in_valid / o_in_ready    | orange, ptt, sk1, sk2 levels, keypad, ticks
// result   | o_out_valid / i_out_ready  | keys_down, short, long, xlong, changed
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An accepted poll is captured in the input register, which feeds the per-key timer
// and classification logic that loads the result register. One poll per cycle is
// sustained unless the result stalls; per-key state updates as the result is loaded.
// A stalled result holds the input register, which then drops o_in_ready.
// Reset (i_rst_n low, synchronous) clears key state and restores config defaults.
module button_long_press_classifier_unit #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_orange_down,
    input  logic                  i_ptt_down,
    input  logic                  i_sk1_down,
    input  logic                  i_sk2_down,
    input  logic                  i_keypad_held,
    input  blpc_pkg::t_elapsed    i_elapsed_ticks,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output blpc_pkg::t_keys       o_keys_down,
    output blpc_pkg::t_key_mask   o_short_released,
    output blpc_pkg::t_key_mask   o_long_held,
    output blpc_pkg::t_key_mask   o_xlong_held,
    output logic                  o_changed,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  blpc_pkg::t_cfg_index  i_cfg_index,
    input  blpc_pkg::t_cfg_data   i_cfg_data
);
    import blpc_pkg::*;

    localparam int DW = (TIMER_WIDTH > ELAPSED_W) ? TIMER_WIDTH : ELAPSED_W;
    localparam int RW = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;
    localparam logic [RW-1:0] TIMER_MAX = RW'((64'd1 << TIMER_WIDTH) - 64'd1);

    // Configuration
    t_cfg_data r_long_press_ticks;
    logic      r_orange_present;

    // Input register
    logic      r_in_valid;
    logic      r_in_orange;
    logic      r_in_ptt;
    logic      r_in_sk1;
    logic      r_in_sk2;
    logic      r_in_keypad;
    t_elapsed  r_in_elapsed;

    // Key state
    t_key_mask              r_pressed, n_pressed;
    t_key_mask              r_long, n_long;
    t_key_mask              r_xlong, n_xlong;
    logic [TIMER_WIDTH-1:0] r_timer [NUM_KEYS];
    logic [TIMER_WIDTH-1:0] n_timer [NUM_KEYS];
    t_word                  r_prev_word, n_prev_word;
    logic                   r_wait, n_wait;

    // Result register
    logic      r_out_valid;
    t_keys     r_keys;
    t_key_mask r_short;
    t_key_mask r_lng;
    t_key_mask r_xl;
    logic      r_changed;
    t_keys     n_keys;
    t_key_mask n_short;
    t_key_mask n_lng;
    t_key_mask n_xl;
    logic      n_changed;

    logic                   advance;
    logic [TIMER_WIDTH-1:0] reload;
    t_key_mask              down;
    t_key_mask              key_en;
    t_keys                  raw;
    logic                   gate;
    t_word                  word;

    // After decrement and newly-down load
    t_key_mask              p1, l1, x1;
    logic [TIMER_WIDTH-1:0] t1 [NUM_KEYS];
    // After reload from levels
    t_key_mask              rp, rl, rx;
    logic [TIMER_WIDTH-1:0] rt [NUM_KEYS];
    // After classification
    t_key_mask              cp, cl, cx;
    logic [TIMER_WIDTH-1:0] ct [NUM_KEYS];
    t_key_mask              sb, lb, xb;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid       = r_out_valid;
    assign o_keys_down       = r_keys;
    assign o_short_released  = r_short;
    assign o_long_held       = r_lng;
    assign o_xlong_held      = r_xl;
    assign o_changed         = r_changed;

    always_comb begin
        if (RW'(r_long_press_ticks) > TIMER_MAX) begin
            reload = TIMER_WIDTH'(TIMER_MAX);
        end else begin
            reload = TIMER_WIDTH'(RW'(r_long_press_ticks));
        end
    end

    assign down   = {r_in_sk2, r_in_sk1, r_in_orange & r_orange_present};
    assign key_en = {2'b11, r_orange_present};
    assign raw    = {down[KEY_SK2], down[KEY_SK1], r_in_ptt, down[KEY_ORANGE]};
    assign gate   = (raw != '0) || r_wait;

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            // Count down by the elapsed ticks, stop at zero
            if (DW'(r_timer[k]) > DW'(r_in_elapsed)) begin
                t1[k] = TIMER_WIDTH'(DW'(r_timer[k]) - DW'(r_in_elapsed));
            end else begin
                t1[k] = '0;
            end
            p1[k] = r_pressed[k];
            l1[k] = r_long[k];
            x1[k] = r_xlong[k];
            if (down[k] && !r_pressed[k]) begin
                p1[k] = 1'b1;
                t1[k] = reload;
                l1[k] = 1'b0;
                x1[k] = 1'b0;
            end

            // Reload from current levels
            if (key_en[k]) begin
                rp[k] = down[k];
                rt[k] = down[k] ? reload : '0;
                rl[k] = 1'b0;
                rx[k] = 1'b0;
            end else begin
                rp[k] = p1[k];
                rt[k] = t1[k];
                rl[k] = l1[k];
                rx[k] = x1[k];
            end

            // Classify
            cp[k] = p1[k];
            ct[k] = t1[k];
            cl[k] = l1[k];
            cx[k] = x1[k];
            sb[k] = 1'b0;
            lb[k] = 1'b0;
            xb[k] = 1'b0;
            if (key_en[k]) begin
                if (down[k] && p1[k] && l1[k] && !x1[k]) begin
                    if (t1[k] == '0) begin
                        cx[k] = 1'b1;
                        xb[k] = 1'b1;
                    end else begin
                        lb[k] = 1'b1;
                    end
                end else if (down[k] && p1[k] && l1[k] && x1[k]) begin
                    xb[k] = 1'b1;
                end else if (down[k] && p1[k] && !l1[k]) begin
                    if (t1[k] == '0) begin
                        cl[k] = 1'b1;
                        lb[k] = 1'b1;
                        ct[k] = reload;
                    end
                end else if (!down[k] && p1[k] && !l1[k] && t1[k] != '0) begin
                    cp[k] = 1'b0;
                    cl[k] = 1'b0;
                    cx[k] = 1'b0;
                    ct[k] = '0;
                    sb[k] = 1'b1;
                end else if (!down[k] && p1[k] && l1[k]) begin
                    cp[k] = 1'b0;
                    cl[k] = 1'b0;
                    cx[k] = 1'b0;
                end
            end
        end
    end

    assign word = {xb, lb, sb, raw};

    always_comb begin
        n_keys    = raw;
        n_short   = '0;
        n_lng     = '0;
        n_xl      = '0;
        n_changed = 1'b0;
        n_wait    = r_wait;
        n_prev_word = r_prev_word;
        n_pressed = p1;
        n_long    = l1;
        n_xlong   = x1;
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_timer[k] = t1[k];
        end

        if (gate && r_in_keypad) begin
            // Keypad in use: enter wait mode, report raw levels only
            n_wait      = 1'b1;
            n_prev_word = WORD_W'(raw);
            n_pressed   = rp;
            n_long      = rl;
            n_xlong     = rx;
            for (int k = 0; k < NUM_KEYS; k++) begin
                n_timer[k] = rt[k];
            end
        end else if (gate && r_wait) begin
            if (WORD_W'(raw) != r_prev_word) begin
                n_wait      = 1'b0;
                n_prev_word = WORD_W'(raw);
                n_changed   = 1'b1;
                n_pressed   = rp;
                n_long      = rl;
                n_xlong     = rx;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    n_timer[k] = rt[k];
                end
            end
        end else begin
            n_short     = sb;
            n_lng       = lb;
            n_xl        = xb;
            n_changed   = (word != r_prev_word);
            n_prev_word = word;
            n_pressed   = cp;
            n_long      = cl;
            n_xlong     = cx;
            for (int k = 0; k < NUM_KEYS; k++) begin
                n_timer[k] = ct[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= LONG_PRESS_RESET;
            r_orange_present   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LONG_PRESS_TICKS:   r_long_press_ticks <= i_cfg_data;
                CFG_ORANGE_KEY_PRESENT: r_orange_present   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the transaction payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_orange  <= i_orange_down;
            r_in_ptt     <= i_ptt_down;
            r_in_sk1     <= i_sk1_down;
            r_in_sk2     <= i_sk2_down;
            r_in_keypad  <= i_keypad_held;
            r_in_elapsed <= i_elapsed_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed   <= '0;
            r_long      <= '0;
            r_xlong     <= '0;
            r_prev_word <= '0;
            r_wait      <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_timer[k] <= '0;
            end
        end else if (advance) begin
            r_pressed   <= n_pressed;
            r_long      <= n_long;
            r_xlong     <= n_xlong;
            r_prev_word <= n_prev_word;
            r_wait      <= n_wait;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_timer[k] <= n_timer[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_keys    <= n_keys;
            r_short   <= n_short;
            r_lng     <= n_lng;
            r_xl      <= n_xl;
            r_changed <= n_changed;
        end
    end

`ifndef ASSERT_OFF
    a_long_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_long & ~r_pressed) == '0) && ((r_xlong & ~r_long) == '0))
        else $error("long flag set on a key that is not pressed");

    a_keypad_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && gate && r_in_keypad) |=> (r_wait && o_out_valid && !o_changed))
        else $error("keypad poll did not enter wait mode quietly");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed poll produced no result");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_prev_word) && $stable(r_wait) && $stable(r_pressed)))
        else $error("key state changed without a poll");
`endif

endmodule

@@ tb/press_class_checker.sv @@
`timescale 1ns / 100ps

module press_class_checker #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 poll_valid,
    input  logic                 poll_ready,
    input  logic                 orange_down,
    input  logic                 ptt_down,
    input  logic                 sk1_down,
    input  logic                 sk2_down,
    input  logic                 keypad_held,
    input  blpc_pkg::t_elapsed   elapsed_ticks,

    input  logic                 result_valid,
    input  logic                 result_ready,
    input  blpc_pkg::t_keys      keys_down,
    input  blpc_pkg::t_key_mask  short_released,
    input  blpc_pkg::t_key_mask  long_held,
    input  blpc_pkg::t_key_mask  xlong_held,
    input  logic                 changed,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  blpc_pkg::t_cfg_index cfg_index,
    input  blpc_pkg::t_cfg_data  cfg_data,

    output int                   n_errors,
    output int                   n_pending
);
    import blpc_pkg::*;

    localparam int SHORT_LSB = KEYS_W;
    localparam int LONG_LSB  = KEYS_W + NUM_KEYS;
    localparam int XLONG_LSB = KEYS_W + 2 * NUM_KEYS;

    typedef logic [TIMER_WIDTH-1:0] t_tick_count;

    typedef struct packed {
        t_keys     keys;
        t_key_mask short_rel;
        t_key_mask long_on;
        t_key_mask xlong_on;
        logic      changed;
    } t_press_result;

    t_tick_count   key_timer_q [NUM_KEYS];
    t_key_mask     held_q;
    t_key_mask     long_q;
    t_key_mask     xlong_q;
    t_word         last_word_q;
    logic          await_change_q;
    t_cfg_data     reload_ticks_q;
    logic          orange_on_q;
    t_press_result expected_q [$];

    function automatic t_tick_count reload_count();
        logic [63:0] cap;
        cap = (64'd1 << TIMER_WIDTH) - 64'd1;
        return t_tick_count'((64'(reload_ticks_q) > cap) ? cap : 64'(reload_ticks_q));
    endfunction

    function automatic t_press_result split_word(input t_word w, input logic chg);
        t_press_result r;
        r.keys      = w[KEYS_W-1:0];
        r.short_rel = w[SHORT_LSB +: NUM_KEYS];
        r.long_on   = w[LONG_LSB +: NUM_KEYS];
        r.xlong_on  = w[XLONG_LSB +: NUM_KEYS];
        r.changed   = chg;
        return r;
    endfunction

    task automatic load_key(input int k, input logic down);
        held_q[k]      = down;
        key_timer_q[k] = down ? reload_count() : '0;
        long_q[k]      = 1'b0;
        xlong_q[k]     = 1'b0;
    endtask

    task automatic reload_keys(input t_key_mask dn);
        load_key(KEY_SK1, dn[KEY_SK1]);
        load_key(KEY_SK2, dn[KEY_SK2]);
        if (orange_on_q)
            load_key(KEY_ORANGE, dn[KEY_ORANGE]);
    endtask

    task automatic classify_key(input int k, input logic down, inout t_word w);
        logic expired;
        expired = (key_timer_q[k] == '0);
        if (down && held_q[k] && long_q[k] && !xlong_q[k]) begin
            if (expired) begin
                xlong_q[k]       = 1'b1;
                w[XLONG_LSB + k] = 1'b1;
            end else begin
                w[LONG_LSB + k] = 1'b1;
            end
        end else if (down && held_q[k] && long_q[k] && xlong_q[k]) begin
            w[XLONG_LSB + k] = 1'b1;
        end else if (down && held_q[k] && !long_q[k]) begin
            if (expired) begin
                long_q[k]       = 1'b1;
                w[LONG_LSB + k] = 1'b1;
                key_timer_q[k]  = reload_count();
            end
        end else if (!down && held_q[k] && !long_q[k] && !expired) begin
            held_q[k]        = 1'b0;
            long_q[k]        = 1'b0;
            xlong_q[k]       = 1'b0;
            key_timer_q[k]   = '0;
            w[SHORT_LSB + k] = 1'b1;
            w[LONG_LSB + k]  = 1'b0;
            w[XLONG_LSB + k] = 1'b0;
        end else if (!down && held_q[k] && long_q[k]) begin
            held_q[k]        = 1'b0;
            long_q[k]        = 1'b0;
            xlong_q[k]       = 1'b0;
            w[LONG_LSB + k]  = 1'b0;
            w[XLONG_LSB + k] = 1'b0;
        end
        // a release right at expiry without a long press leaves the key held
    endtask

    task automatic classify_poll(output t_press_result r);
        t_key_mask dn;
        t_word     w;
        logic      chg;
        dn[KEY_ORANGE] = orange_on_q & orange_down;
        dn[KEY_SK1]    = sk1_down;
        dn[KEY_SK2]    = sk2_down;

        for (int k = 0; k < NUM_KEYS; k++)
            key_timer_q[k] = (key_timer_q[k] > elapsed_ticks) ?
                             key_timer_q[k] - elapsed_ticks : '0;

        w    = '0;
        w[0] = dn[KEY_ORANGE];
        w[1] = ptt_down;
        w[2] = dn[KEY_SK1];
        w[3] = dn[KEY_SK2];

        for (int k = 0; k < NUM_KEYS; k++)
            if (dn[k] && !held_q[k])
                load_key(k, 1'b1);

        if (w != '0 || await_change_q) begin
            if (keypad_held) begin
                await_change_q = 1'b1;
                reload_keys(dn);
                last_word_q = w;
                r = split_word(w, 1'b0);
                return;
            end
            if (await_change_q) begin
                if (w != last_word_q) begin
                    await_change_q = 1'b0;
                    reload_keys(dn);
                    last_word_q = w;
                    r = split_word(w, 1'b1);
                end else begin
                    r = split_word(w, 1'b0);
                end
                return;
            end
        end

        if (orange_on_q)
            classify_key(KEY_ORANGE, dn[KEY_ORANGE], w);
        classify_key(KEY_SK1, dn[KEY_SK1], w);
        classify_key(KEY_SK2, dn[KEY_SK2], w);

        chg         = (w != last_word_q);
        last_word_q = w;
        r = split_word(w, chg);
    endtask

    task automatic check_field(input string name, input int want, input int got,
                               inout int bad);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad++;
        end
    endtask

    always @(posedge clk) begin
        t_press_result want;
        t_press_result got;
        int            bad;
        bad = 0;
        if (!rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++)
                key_timer_q[k] = '0;
            held_q         = '0;
            long_q         = '0;
            xlong_q        = '0;
            last_word_q    = '0;
            await_change_q = 1'b0;
            reload_ticks_q = LONG_PRESS_RESET;
            orange_on_q    = 1'b1;
            expected_q.delete();
            n_errors  <= 0;
            n_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LONG_PRESS_TICKS:   reload_ticks_q = cfg_data;
                    CFG_ORANGE_KEY_PRESENT: orange_on_q = cfg_data[0];
                    default: ;
                endcase
            end

            // compare before queuing this edge's poll: a result can never belong to it
            if (result_valid && result_ready) begin
                got = {keys_down, short_released, long_held, xlong_held, changed};
                if (expected_q.size() == 0) begin
                    $error("result transaction with no poll outstanding");
                    bad++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("keys_down", int'(want.keys), int'(got.keys), bad);
                    check_field("short_released", int'(want.short_rel),
                                int'(got.short_rel), bad);
                    check_field("long_held", int'(want.long_on), int'(got.long_on), bad);
                    check_field("xlong_held", int'(want.xlong_on), int'(got.xlong_on),
                                bad);
                    check_field("changed", int'(want.changed), int'(got.changed), bad);
                end
            end

            if (poll_valid && poll_ready) begin
                classify_poll(want);
                expected_q.push_back(want);
            end

            n_errors  <= n_errors + bad;
            n_pending <= expected_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import blpc_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 5000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       orange = 1'b0;
    logic       ptt = 1'b0;
    logic       sk1 = 1'b0;
    logic       sk2 = 1'b0;
    logic       keypad = 1'b0;
    t_elapsed   ticks = '0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    t_keys      keys_down;
    t_key_mask  short_released;
    t_key_mask  long_held;
    t_key_mask  xlong_held;
    logic       changed;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    t_cfg_index cfg_index = '0;
    t_cfg_data  cfg_data = '0;

    int         n_errors;
    int         n_pending;

    logic       steady = 1'b0;
    int         holds_asked = 0;
    int         poll_count = 0;
    logic [3:0] key_levels = '0;

    always #5 clk = ~clk;

    button_long_press_classifier_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_orange_down     (orange),
        .i_ptt_down        (ptt),
        .i_sk1_down        (sk1),
        .i_sk2_down        (sk2),
        .i_keypad_held     (keypad),
        .i_elapsed_ticks   (ticks),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_keys_down       (keys_down),
        .o_short_released  (short_released),
        .o_long_held       (long_held),
        .o_xlong_held      (xlong_held),
        .o_changed         (changed),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    press_class_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .poll_valid      (in_valid),
        .poll_ready      (in_ready),
        .orange_down     (orange),
        .ptt_down        (ptt),
        .sk1_down        (sk1),
        .sk2_down        (sk2),
        .keypad_held     (keypad),
        .elapsed_ticks   (ticks),
        .result_valid    (out_valid),
        .result_ready    (out_ready),
        .keys_down       (keys_down),
        .short_released  (short_released),
        .long_held       (long_held),
        .xlong_held      (xlong_held),
        .changed         (changed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .n_errors        (n_errors),
        .n_pending       (n_pending)
    );

    // Result side: random backpressure, plus long hold-offs on request.
    initial begin : result_sink
        int holds_served;
        int stall_left;
        holds_served = 0;
        stall_left   = 0;
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady || ($urandom_range(99) >= 36);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_poll(input logic o, input logic p, input logic s1, input logic s2,
                             input logic kp, input t_elapsed t);
        while (!steady && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        orange   <= o;
        ptt      <= p;
        sk1      <= s1;
        sk2      <= s2;
        keypad   <= kp;
        ticks    <= t;
        do @(posedge clk); while (!in_ready);
        poll_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_cfg_data value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned reload, input logic orange_on);
        drain_results();
        // let the pipeline settle before touching the registers
        repeat (4) @(posedge clk);
        write_reg(CFG_LONG_PRESS_TICKS, t_cfg_data'(reload));
        write_reg(CFG_ORANGE_KEY_PRESENT, t_cfg_data'(orange_on));
    endtask

    // Elapsed ticks sized against the reload so that long and extra-long presses occur.
    function automatic t_elapsed pick_ticks(input int unsigned reload);
        int unsigned span;
        int unsigned roll;
        span = (reload > 65535) ? 65535 : reload;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        else if (roll < 55)
            return t_elapsed'($urandom_range(span / 3));
        else if (roll < 70)
            return t_elapsed'(span);
        else if (roll < 80)
            return t_elapsed'($urandom);
        else if (roll < 85)
            return '1;
        else
            return t_elapsed'($urandom_range(8, 1));
    endfunction

    task automatic run_random(input int n, input int unsigned reload, input logic orange_on);
        logic [3:0] lv;
        logic       kp;
        set_config(reload, orange_on);
        for (int i = 0; i < n; i++) begin
            if (poll_count == 150)
                holds_asked <= holds_asked + 1;
            if (poll_count == 250)
                steady <= 1'b1;
            if (poll_count == 400)
                steady <= 1'b0;
            if (poll_count == 450)
                drain_results();

            // mostly held keys that toggle now and then; some polls are pure noise
            if ($urandom_range(9) == 0) begin
                lv = 4'($urandom);
            end else begin
                lv = key_levels;
                for (int b = 0; b < 4; b++)
                    if ($urandom_range(99) < 20)
                        lv[b] = ~lv[b];
            end
            key_levels = lv;
            kp = ($urandom_range(99) < 8);
            send_poll(lv[0], lv[1], lv[2], lv[3], kp, pick_ticks(reload));
        end
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        set_config(100, 1'b1);
        send_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
        // short press and release
        send_poll(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd10);
        send_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd10);
        // long, then extra-long, then release
        send_poll(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0);
        send_poll(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd100);
        send_poll(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd50);
        send_poll(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'hFFFF);
        send_poll(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0);
        send_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
        // release exactly at expiry keeps the key held
        send_poll(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0);
        send_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd100);
        send_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
        send_poll(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0);
        send_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
        // keypad modifier enters wait mode, a new word leaves it
        send_poll(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd3);
        send_poll(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'd3);
        send_poll(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd3);
        send_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
        // all keys at once, largest tick steps
        send_poll(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF);
        send_poll(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF);
        send_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0);
        send_poll(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd1);

        run_random(500, 100, 1'b1);
        run_random(200, 0, 1'b0);
        run_random(150, 24'hFFFFFF, 1'b1);
        repeat (4)
            run_random(100, $urandom_range(2000, 1), 1'($urandom_range(1)));
        run_random(200, LONG_PRESS_RESET, 1'b1);

        drain_results();
        repeat (4) @(posedge clk);
        if (n_errors == 0 && n_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/blpc_pkg.sv
rtl/button_long_press_classifier_unit.sv
tb/press_class_checker.sv
tb/tb.sv
